FILE: hdl/grid_density_point_filter_defines.svh
// Assertion macros for the grid density point filter checker.
// No dependencies; include by bare file name before the module that asserts.
`ifndef GRID_DENSITY_POINT_FILTER_DEFINES_SVH
`define GRID_DENSITY_POINT_FILTER_DEFINES_SVH

// Same-cycle implication, quiet while reset is held.
`define GDPF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is held.
`define GDPF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/gdpf_pkg.sv
// Shared types and constants of the grid density point filter.
// No dependencies; compile before every other file of the block.
package gdpf_pkg;

  localparam int COORD_W    = 16;
  localparam int COUNT_W    = 16;
  localparam int DROP_W     = 13;
  localparam int SHIFT_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SHIFT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_POINTS = 1'b1;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd5;
  localparam logic [COUNT_W-1:0] MIN_RESET   = 16'd5;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;
  localparam logic [DROP_W-1:0]  DROP_LIMIT  = 13'd4096;

  typedef struct packed {
    logic                      operation;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic signed [COORD_W-1:0] z_coord;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      found;
    logic [DROP_W-1:0]         dropped;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
  } point_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_WR,
    ST_DR_FETCH,
    ST_DR_CELL,
    ST_DR_TEST
  } state_t;

endpackage

FILE: hdl/gdpf_cell.sv
// Cell locator: floor-shifts a point into grid cell coordinates and flattens them.
// Depends on gdpf_pkg.
module gdpf_cell #(
  parameter int GRID_SIDE = 64
) (
  input  logic signed [gdpf_pkg::COORD_W-1:0]         x_coord,
  input  logic signed [gdpf_pkg::COORD_W-1:0]         y_coord,
  input  logic        [gdpf_pkg::SHIFT_W-1:0]         cell_shift,
  output logic                                        in_window,
  output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]      cell_idx
);
  import gdpf_pkg::*;

  localparam int HALF   = GRID_SIDE / 2;
  localparam int CELL_W = $clog2(GRID_SIDE * GRID_SIDE);
  localparam int AX_W   = $clog2(GRID_SIDE);
  localparam logic signed [COORD_W:0] HALF_C   = (COORD_W + 1)'(HALF);
  localparam logic        [COORD_W:0] SIDE_C   = (COORD_W + 1)'(GRID_SIDE);
  localparam logic     [CELL_W-1:0]   STRIDE_C = CELL_W'(GRID_SIDE);

  logic signed [COORD_W-1:0] sx, sy;
  logic signed [COORD_W:0]   cx, cy;

  // arithmetic shift gives the floor of the division
  assign sx = x_coord >>> cell_shift;
  assign sy = y_coord >>> cell_shift;
  assign cx = (COORD_W + 1)'(sx) + HALF_C;
  assign cy = (COORD_W + 1)'(sy) + HALF_C;

  assign in_window = !cx[COORD_W] && ($unsigned(cx) < SIDE_C) &&
                     !cy[COORD_W] && ($unsigned(cy) < SIDE_C);
  assign cell_idx  = CELL_W'(cx[AX_W-1:0]) + CELL_W'(cy[AX_W-1:0]) * STRIDE_C;

endmodule

FILE: hdl/grid_density_point_filter.sv
// Grid density point filter. A load beat is accepted in ST_IDLE and its counter is written back
// in ST_LD_WR (a dropped beat stays in ST_IDLE), one beat at a time. A drain beat walks stored
// points through ST_DR_FETCH, ST_DR_CELL and ST_DR_TEST, skipping points outside the window
// or in a sparse cell; a kept point waits for a free result register, as does an exhausted drain.
// Reset (synchronous, rst_n low) and every exhausted drain start a clearing pass over all
// GRID_SIDE*GRID_SIDE counters of the counter memory; no beat is taken until it ends.
module grid_density_point_filter #(
  parameter int GRID_SIDE  = 64,
  parameter int MAX_POINTS = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  gdpf_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output gdpf_pkg::out_item_t                   out_data,
  input  logic                                  cfg_we,
  input  logic [gdpf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gdpf_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import gdpf_pkg::*;

  localparam int CELLS  = GRID_SIDE * GRID_SIDE;
  localparam int CELL_W = $clog2(CELLS);
  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int POS_W  = $clog2(MAX_POINTS + 1);
  localparam logic [POS_W-1:0]  FULL_C    = POS_W'(MAX_POINTS);
  localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);

  // Control state
  state_t              state_r, state_nxt;
  logic [CELL_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [POS_W-1:0]    stored_r, stored_nxt;
  logic [POS_W-1:0]    drain_r, drain_nxt;
  logic [DROP_W-1:0]   dropped_r, dropped_nxt;
  logic [SHIFT_W-1:0]  cell_shift_r;
  logic [COUNT_W-1:0]  min_points_r;
  logic                out_valid_r, out_valid_nxt;

  // Payload registers
  logic [CELL_W-1:0]   ld_idx_r, ld_idx_nxt;
  out_item_t           out_data_r, out_data_nxt;

  // Memory ports
  logic [COUNT_W-1:0]  cnt_mem [CELLS];
  logic [COUNT_W-1:0]  cnt_q;
  logic                cnt_re, cnt_we;
  logic [CELL_W-1:0]   cnt_ra, cnt_wa;
  logic [COUNT_W-1:0]  cnt_wd;

  point_t              pt_mem [MAX_POINTS];
  point_t              pt_q;
  logic                pt_re, pt_we;
  logic [ADDR_W-1:0]   pt_ra, pt_wa;
  point_t              pt_wd;

  // Cell locator, shared by the load path (input beat) and the drain path (read point)
  logic signed [COORD_W-1:0] cell_x, cell_y;
  logic                      cell_ok;
  logic [CELL_W-1:0]         cell_idx;
  logic                      out_free;

  assign cell_x = (state_r == ST_IDLE) ? in_data.x_coord : pt_q.px;
  assign cell_y = (state_r == ST_IDLE) ? in_data.y_coord : pt_q.py;

  gdpf_cell #(
    .GRID_SIDE (GRID_SIDE)
  ) u_cell (
    .x_coord    (cell_x),
    .y_coord    (cell_y),
    .cell_shift (cell_shift_r),
    .in_window  (cell_ok),
    .cell_idx   (cell_idx)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  // the result register is free when empty or being taken this cycle
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    stored_nxt    = stored_r;
    drain_nxt     = drain_r;
    dropped_nxt   = dropped_r;
    ld_idx_nxt    = ld_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    cnt_re = 1'b0;
    cnt_ra = cell_idx;
    cnt_we = 1'b0;
    cnt_wa = ld_idx_r;
    cnt_wd = '0;
    pt_re  = 1'b0;
    pt_ra  = drain_r[ADDR_W-1:0];
    pt_we  = 1'b0;
    pt_wa  = stored_r[ADDR_W-1:0];
    pt_wd  = '{px: in_data.x_coord, py: in_data.y_coord, pz: in_data.z_coord};

    case (state_r)
      ST_CLEAR: begin
        // sweep one counter per cycle back to zero
        cnt_we       = 1'b1;
        cnt_wa       = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_CELL) begin
          clr_addr_nxt = '0;
          state_nxt    = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.operation == OP_LOAD) begin
            if (stored_r == FULL_C || !cell_ok) begin
              // drop the point: buffer full or cell outside the window
              if (dropped_r != DROP_LIMIT) begin
                dropped_nxt = dropped_r + 1'b1;
              end
            end else begin
              // buffer the point and fetch its cell counter
              cnt_re     = 1'b1;
              ld_idx_nxt = cell_idx;
              pt_we      = 1'b1;
              stored_nxt = stored_r + 1'b1;
              state_nxt  = ST_LD_WR;
            end
          end else begin
            state_nxt = ST_DR_FETCH;
          end
        end
      end
      ST_LD_WR: begin
        // write back the saturating increment
        cnt_we    = 1'b1;
        cnt_wd    = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_DR_FETCH: begin
        if (drain_r < stored_r) begin
          pt_re     = 1'b1;
          drain_nxt = drain_r + 1'b1;
          state_nxt = ST_DR_CELL;
        end else if (out_free) begin
          // cloud exhausted: report, reset the cloud and clear the grid
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{out_x: '0, out_y: '0, out_z: '0, found: 1'b0,
                            dropped: dropped_r};
          stored_nxt    = '0;
          drain_nxt     = '0;
          dropped_nxt   = '0;
          clr_addr_nxt  = '0;
          state_nxt     = ST_CLEAR;
        end
      end
      ST_DR_CELL: begin
        // locate the stored point with the current shift
        if (cell_ok) begin
          cnt_re    = 1'b1;
          state_nxt = ST_DR_TEST;
        end else begin
          state_nxt = ST_DR_FETCH;
        end
      end
      ST_DR_TEST: begin
        if (cnt_q >= min_points_r) begin
          // hold until the result register is free
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{out_x: pt_q.px, out_y: pt_q.py, out_z: pt_q.pz,
                              found: 1'b1, dropped: dropped_r};
            state_nxt     = ST_IDLE;
          end
        end else begin
          state_nxt = ST_DR_FETCH;
        end
      end
      default: begin
        state_nxt    = ST_CLEAR;
        clr_addr_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      stored_r     <= '0;
      drain_r      <= '0;
      dropped_r    <= '0;
      out_valid_r  <= 1'b0;
      cell_shift_r <= SHIFT_RESET;
      min_points_r <= MIN_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      stored_r    <= stored_nxt;
      drain_r     <= drain_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_CELL_SHIFT: cell_shift_r <= cfg_data[SHIFT_W-1:0];
          CFG_MIN_POINTS: min_points_r <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ld_idx_r   <= ld_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  // Cell counter memory: one access per cycle, registered read
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cnt_re) begin
      cnt_q <= cnt_mem[cnt_ra];
    end
  end

  // Point buffer: written in load order, read in drain order
  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_wa] <= pt_wd;
    end
    if (pt_re) begin
      pt_q <= pt_mem[pt_ra];
    end
  end

endmodule

FILE: hdl/gdpf_checker.sv
// Port-level checker for the grid density point filter, bound to the top level.
// Depends on gdpf_pkg and grid_density_point_filter_defines.svh.
`include "grid_density_point_filter_defines.svh"

module gdpf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input gdpf_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input gdpf_pkg::out_item_t out_data
);
  import gdpf_pkg::*;

  `GDPF_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")
  `GDPF_ASSERT_IMP(a_empty_zero, clk, rst_n, out_valid && !out_data.found, out_data.out_x == 0 && out_data.out_y == 0 && out_data.out_z == 0, "exhausted result carries a point")
  `GDPF_ASSERT_IMP(a_drop_sat, clk, rst_n, out_valid, out_data.dropped <= DROP_LIMIT, "drop count above its limit")
  `GDPF_ASSERT_NXT(a_drain_busy, clk, rst_n, in_valid && in_ready && in_data.operation == OP_DRAIN, !in_ready, "input taken while a drain is in progress")

endmodule

bind grid_density_point_filter gdpf_checker u_gdpf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
